[rtl/core/pmpc_pkg.sv]
`default_nettype none
package pmpc_pkg;

    localparam int DRAM_WORDS = 65536;
    localparam int IRAM_WORDS = 1024;
    localparam int DRAM_AW    = $clog2(DRAM_WORDS);
    localparam int IRAM_AW    = $clog2(IRAM_WORDS);

    localparam logic [2:0] CMD_DSP_RD  = 3'd0;
    localparam logic [2:0] CMD_DSP_WR  = 3'd1;
    localparam logic [2:0] CMD_CART_RD = 3'd2;
    localparam logic [2:0] CMD_CART_WR = 3'd3;
    localparam logic [2:0] CMD_REG_RD  = 3'd4;
    localparam logic [2:0] CMD_REG_WR  = 3'd5;

    localparam logic [2:0] PORT_STATUS  = 3'd3;
    localparam logic [2:0] PORT_PM4     = 3'd4;
    localparam logic [2:0] PORT_CONTROL = 3'd6;
    localparam logic [2:0] PORT_AL      = 3'd7;

    localparam logic [1:0] OC_OK       = 2'd0;
    localparam logic [1:0] OC_BAD_MODE = 2'd1;
    localparam logic [1:0] OC_NO_PTR   = 2'd2;
    localparam logic [1:0] OC_UNMAPPED = 2'd3;

    localparam logic [15:0] WR_DRAM_MASK  = 16'h43ff;
    localparam logic [15:0] WR_DRAM_VAL   = 16'h0018;
    localparam logic [15:0] WR_CELL_MASK  = 16'hfbff;
    localparam logic [15:0] WR_CELL_VAL   = 16'h4018;
    localparam logic [15:0] IRAM_MASK     = 16'h47ff;
    localparam logic [15:0] IRAM_VAL      = 16'h001c;
    localparam logic [15:0] ROM_MASK      = 16'hfff0;
    localparam logic [15:0] ROM_VAL       = 16'h0800;
    localparam logic [15:0] RD_DRAM_VAL   = 16'h0018;

    localparam logic [4:0] WIN_PLAIN = 5'h18;
    localparam logic [5:0] WIN_SCR1  = 6'h39;
    localparam logic [5:0] WIN_SCR2  = 6'h3a;

    function automatic logic [31:0] step_of(input logic [15:0] mode);
        logic [31:0] s;
        unique case (mode[13:11])
            3'd0: s = 32'd0;
            3'd1: s = 32'd1;
            3'd2: s = 32'd2;
            3'd3: s = 32'd4;
            3'd4: s = 32'd8;
            3'd5: s = 32'd16;
            3'd6: s = 32'd32;
            default: s = 32'd128;
        endcase
        if (mode[15])
            s = 32'd0 - s;
        return s;
    endfunction

    function automatic logic [15:0] nibble_merge(input logic [15:0] old, input logic [15:0] d);
        logic [15:0] r;
        r = old;
        for (int i = 0; i < 4; i++)
            if (d[i*4 +: 4] != 4'd0)
                r[i*4 +: 4] = d[i*4 +: 4];
        return r;
    endfunction

endpackage
`default_nettype wire

[rtl/core/pmpc_ram.sv]
`default_nettype none
module pmpc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        if (re)
            rdata <= mem[addr];
    end

endmodule
`default_nettype wire

[rtl/core/programmable_memory_port_controller.sv]
`default_nettype none
// Memory port controller for a DSP bus and a host bus.
// Input channel: in_valid/in_stall carries one transaction (command, port,
// host_offset, write_data, gpo_bits). Output channel: out_valid/out_stall
// carries exactly one result (read_data, rom_request, rom_address, outcome)
// for every input transaction, in order.
// A transaction is taken in the IDLE state and executed in EXEC after it;
// anything that reads DRAM (pointer reads, cartridge window reads,
// nibble-overwrite writes) then passes through the MEM state on the
// registered DRAM read port. Results are registered on leaving EXEC, or MEM
// when DRAM is read. No new transaction is taken while one is in EXEC or MEM.
// A new transaction is taken only once the output register is empty or
// being emptied, so a stalled receiver holds the result and stalls the input.
// Reset clears all pointers, the control word, handshake phase, status and
// mailbox registers. DRAM and IRAM contents are undefined until written;
// there is no clearing pass.
module programmable_memory_port_controller (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [2:0]  command,
    input  wire logic [2:0]  port,
    input  wire logic [20:0] host_offset,
    input  wire logic [15:0] write_data,
    input  wire logic [1:0]  gpo_bits,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [15:0]      read_data,
    output logic             rom_request,
    output logic [19:0]      rom_address,
    output logic [1:0]       outcome
);

    typedef enum logic [1:0] {S_IDLE, S_EXEC, S_MEM} state_t;

    state_t state_reg, state_next;
    logic [2:0]  cmd_reg, cmd_next;
    logic [2:0]  port_reg, port_next;
    logic [20:0] off_reg, off_next;
    logic [15:0] wd_reg, wd_next;
    logic [1:0]  gpo_reg, gpo_next;
    logic [31:0] rp_reg [5];
    logic [31:0] rp_next [5];
    logic [31:0] wp_reg [5];
    logic [31:0] wp_next [5];
    logic [31:0] cw_reg, cw_next;
    logic [1:0]  phase_reg, phase_next;
    logic [15:0] status_reg, status_next;
    logic [15:0] mbox_reg, mbox_next;
    logic        merge_reg, merge_next;
    logic [15:0] maddr_reg, maddr_next;
    logic        out_valid_reg, out_valid_next;
    logic [15:0] rd_reg, rd_next;
    logic        rreq_reg, rreq_next;
    logic [19:0] raddr_reg, raddr_next;
    logic [1:0]  oc_reg, oc_next;

    logic                          dram_we, dram_re;
    logic [pmpc_pkg::DRAM_AW-1:0]  dram_addr;
    logic [15:0]                   dram_wdata, dram_q;
    logic                          iram_we;
    logic [pmpc_pkg::IRAM_AW-1:0]  iram_addr;

    logic        wr;
    logic [31:0] ptr, ptr_new;
    logic [15:0] mode, paddr, lo;
    logic [14:0] sa;

    pmpc_ram #(.WIDTH(16), .DEPTH(pmpc_pkg::DRAM_WORDS)) u_dram (
        .clk(clk), .we(dram_we), .re(dram_re), .addr(dram_addr),
        .wdata(dram_wdata), .rdata(dram_q)
    );

    pmpc_ram #(.WIDTH(16), .DEPTH(pmpc_pkg::IRAM_WORDS)) u_iram (
        .clk(clk), .we(iram_we), .re(1'b0), .addr(iram_addr),
        .wdata(wd_reg), .rdata()
    );

    assign in_stall    = !(state_reg == S_IDLE && (!out_valid_reg || !out_stall));
    assign out_valid   = out_valid_reg;
    assign read_data   = rd_reg;
    assign rom_request = rreq_reg;
    assign rom_address = raddr_reg;
    assign outcome     = oc_reg;

    assign wr    = cmd_reg[0];
    assign ptr   = wr ? wp_reg[port_reg] : rp_reg[port_reg];
    assign mode  = ptr[31:16];
    assign paddr = ptr[15:0];
    assign lo    = cw_reg[15:0];

    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        port_next   = port_reg;
        off_next    = off_reg;
        wd_next     = wd_reg;
        gpo_next    = gpo_reg;
        rp_next     = rp_reg;
        wp_next     = wp_reg;
        cw_next     = cw_reg;
        phase_next  = phase_reg;
        status_next = status_reg;
        mbox_next   = mbox_reg;
        merge_next  = merge_reg;
        maddr_next  = maddr_reg;
        rd_next     = rd_reg;
        rreq_next   = rreq_reg;
        raddr_next  = raddr_reg;
        oc_next     = oc_reg;
        out_valid_next = out_valid_reg && out_stall;
        dram_we    = 1'b0;
        dram_re    = 1'b0;
        dram_addr  = maddr_reg;
        dram_wdata = wd_reg;
        iram_we    = 1'b0;
        iram_addr  = paddr[pmpc_pkg::IRAM_AW-1:0];
        ptr_new    = ptr;
        sa         = off_reg[14:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && !in_stall)
                begin
                    cmd_next   = command;
                    port_next  = port;
                    off_next   = host_offset;
                    wd_next    = write_data;
                    gpo_next   = gpo_bits;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                rd_next    = 16'd0;
                rreq_next  = 1'b0;
                raddr_next = 20'd0;
                oc_next    = pmpc_pkg::OC_OK;
                merge_next = 1'b0;
                out_valid_next = 1'b1;
                state_next = S_IDLE;
                if (cmd_reg == pmpc_pkg::CMD_DSP_RD || cmd_reg == pmpc_pkg::CMD_DSP_WR)
                begin
                    if (port_reg <= pmpc_pkg::PORT_PM4)
                    begin
                        if (phase_reg[1])
                        begin
                            if (wr)
                                wp_next[port_reg] = cw_reg;
                            else
                                rp_next[port_reg] = cw_reg;
                            phase_next[1] = 1'b0;
                        end
                        else
                        begin
                            phase_next[0] = 1'b0;
                            if (port_reg == pmpc_pkg::PORT_PM4 || gpo_reg != 2'd0)
                            begin
                                if (wr)
                                begin
                                    if ((mode & pmpc_pkg::WR_DRAM_MASK) == pmpc_pkg::WR_DRAM_VAL
                                        || (mode & pmpc_pkg::WR_CELL_MASK)
                                           == pmpc_pkg::WR_CELL_VAL)
                                    begin
                                        if ((mode & pmpc_pkg::WR_DRAM_MASK)
                                            == pmpc_pkg::WR_DRAM_VAL)
                                            ptr_new = ptr + pmpc_pkg::step_of(mode);
                                        else
                                            ptr_new = ptr + (paddr[0] ? 32'd31 : 32'd1);
                                        maddr_next = paddr;
                                        if (mode[10])
                                        begin
                                            dram_re        = 1'b1;
                                            dram_addr      = paddr;
                                            merge_next     = 1'b1;
                                            out_valid_next = 1'b0;
                                            state_next     = S_MEM;
                                        end
                                        else
                                        begin
                                            dram_we   = 1'b1;
                                            dram_addr = paddr;
                                        end
                                    end
                                    else if ((mode & pmpc_pkg::IRAM_MASK) == pmpc_pkg::IRAM_VAL)
                                    begin
                                        iram_we = 1'b1;
                                        ptr_new = ptr + pmpc_pkg::step_of(mode);
                                    end
                                    else
                                        oc_next = pmpc_pkg::OC_BAD_MODE;
                                end
                                else
                                begin
                                    if ((mode & pmpc_pkg::ROM_MASK) == pmpc_pkg::ROM_VAL)
                                    begin
                                        rreq_next  = 1'b1;
                                        raddr_next = {mode[3:0], paddr};
                                        ptr_new    = ptr + 32'd1;
                                    end
                                    else if ((mode & pmpc_pkg::IRAM_MASK)
                                             == pmpc_pkg::RD_DRAM_VAL)
                                    begin
                                        dram_re        = 1'b1;
                                        dram_addr      = paddr;
                                        ptr_new        = ptr + pmpc_pkg::step_of(mode);
                                        out_valid_next = 1'b0;
                                        state_next     = S_MEM;
                                    end
                                    else
                                        oc_next = pmpc_pkg::OC_BAD_MODE;
                                end
                                if (wr)
                                    wp_next[port_reg] = ptr_new;
                                else
                                    rp_next[port_reg] = ptr_new;
                                cw_next = ptr_new;
                            end
                            else if (port_reg == 3'd0)
                            begin
                                if (wr)
                                    mbox_next = wd_reg;
                                else
                                begin
                                    rd_next   = mbox_reg;
                                    mbox_next = mbox_reg & ~16'd2;
                                end
                            end
                            else if (port_reg == pmpc_pkg::PORT_STATUS)
                            begin
                                if (wr)
                                begin
                                    mbox_next   = mbox_reg | 16'd1;
                                    status_next = wd_reg;
                                end
                                else
                                    rd_next = status_reg;
                            end
                            else
                                oc_next = pmpc_pkg::OC_NO_PTR;
                        end
                    end
                    else if (port_reg == pmpc_pkg::PORT_CONTROL)
                    begin
                        if (phase_reg[0])
                        begin
                            phase_next = 2'b10;
                            if (wr)
                                cw_next = {wd_reg, lo};
                            else
                                rd_next = {lo[11:0], lo[7:4]};
                        end
                        else
                        begin
                            phase_next[0] = 1'b1;
                            if (wr)
                                cw_next = {cw_reg[31:16], wd_reg};
                            else
                                rd_next = lo;
                        end
                    end
                    else if (port_reg == pmpc_pkg::PORT_AL)
                    begin
                        if (!wr)
                            phase_next = 2'b00;
                    end
                end
                else if (cmd_reg == pmpc_pkg::CMD_CART_RD)
                begin
                    if (off_reg[20:16] == pmpc_pkg::WIN_PLAIN)
                    begin
                        dram_re    = 1'b1;
                        dram_addr  = off_reg[15:0];
                        out_valid_next = 1'b0;
                        state_next = S_MEM;
                    end
                    else if (off_reg[20:15] == pmpc_pkg::WIN_SCR1)
                    begin
                        dram_re    = 1'b1;
                        dram_addr  = {1'b0, (sa & 15'h7001) | {3'd0, sa[5:1], 7'd0}
                                      | {8'd0, sa[11:6], 1'b0}};
                        out_valid_next = 1'b0;
                        state_next = S_MEM;
                    end
                    else if (off_reg[20:15] == pmpc_pkg::WIN_SCR2)
                    begin
                        dram_re    = 1'b1;
                        dram_addr  = {1'b0, (sa & 15'h7801) | {4'd0, sa[4:1], 7'd0}
                                      | {8'd0, sa[10:5], 1'b0}};
                        out_valid_next = 1'b0;
                        state_next = S_MEM;
                    end
                    else if (!off_reg[20])
                    begin
                        rreq_next  = 1'b1;
                        raddr_next = off_reg[19:0];
                    end
                    else
                    begin
                        rd_next = 16'hffff;
                        oc_next = pmpc_pkg::OC_UNMAPPED;
                    end
                end
                else if (cmd_reg == pmpc_pkg::CMD_CART_WR)
                begin
                    if (off_reg[20:16] == pmpc_pkg::WIN_PLAIN)
                    begin
                        dram_we   = 1'b1;
                        dram_addr = off_reg[15:0];
                    end
                    else
                        oc_next = pmpc_pkg::OC_UNMAPPED;
                end
                else if (cmd_reg == pmpc_pkg::CMD_REG_RD)
                begin
                    if (off_reg <= 21'd1)
                        rd_next = status_reg;
                    else if (off_reg == 21'd2)
                    begin
                        rd_next   = mbox_reg;
                        mbox_next = mbox_reg & ~16'd1;
                    end
                    else
                        oc_next = pmpc_pkg::OC_UNMAPPED;
                end
                else if (cmd_reg == pmpc_pkg::CMD_REG_WR)
                begin
                    if (off_reg <= 21'd1)
                    begin
                        status_next = wd_reg;
                        mbox_next   = mbox_reg | 16'd2;
                    end
                    else if (off_reg != 21'd3)
                        oc_next = pmpc_pkg::OC_UNMAPPED;
                end
            end
            S_MEM:
            begin
                if (merge_reg)
                begin
                    dram_we    = 1'b1;
                    dram_addr  = maddr_reg;
                    dram_wdata = pmpc_pkg::nibble_merge(dram_q, wd_reg);
                end
                else
                    rd_next = dram_q;
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            cw_reg        <= 32'd0;
            phase_reg     <= 2'd0;
            status_reg    <= 16'd0;
            mbox_reg      <= 16'd0;
            for (int i = 0; i < 5; i++)
            begin
                rp_reg[i] <= 32'd0;
                wp_reg[i] <= 32'd0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            cw_reg        <= cw_next;
            phase_reg     <= phase_next;
            status_reg    <= status_next;
            mbox_reg      <= mbox_next;
            rp_reg        <= rp_next;
            wp_reg        <= wp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        port_reg  <= port_next;
        off_reg   <= off_next;
        wd_reg    <= wd_next;
        gpo_reg   <= gpo_next;
        merge_reg <= merge_next;
        maddr_reg <= maddr_next;
        rd_reg    <= rd_next;
        rreq_reg  <= rreq_next;
        raddr_reg <= raddr_next;
        oc_reg    <= oc_next;
    end

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> state_reg == S_EXEC)
        else $error("accepted transaction not executed");

    a_exec_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC) |-> !out_valid_reg)
        else $error("result register busy during execute");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_EXEC || $past(state_reg) == S_MEM))
        else $error("result without execution");

    a_mem_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MEM) |-> ($past(state_reg) == S_EXEC))
        else $error("memory phase out of sequence");

endmodule
`default_nettype wire

[dv/tb_top.sv]
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [2:0]  port;
        logic [20:0] off;
        logic [15:0] wd;
        logic [1:0]  gpo;
    } access_t;

    typedef struct packed {
        logic [15:0] rd;
        logic        rreq;
        logic [19:0] raddr;
        logic [1:0]  oc;
    } reply_t;

    typedef struct {
        access_t acc;
        bit      known;
        reply_t  rep;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [2:0]  command;
    logic [2:0]  port;
    logic [20:0] host_offset;
    logic [15:0] write_data;
    logic [1:0]  gpo_bits;
    logic        out_valid;
    logic        out_stall;
    logic [15:0] read_data;
    logic        rom_request;
    logic [19:0] rom_address;
    logic [1:0]  outcome;

    programmable_memory_port_controller uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .command(command), .port(port), .host_offset(host_offset),
        .write_data(write_data), .gpo_bits(gpo_bits),
        .out_valid(out_valid), .out_stall(out_stall),
        .read_data(read_data), .rom_request(rom_request),
        .rom_address(rom_address), .outcome(outcome)
    );

    // shadow state of the controller
    logic [31:0] rd_ptr [5];
    logic [31:0] wr_ptr [5];
    logic [31:0] ctl_word;
    logic [1:0]  phase;
    logic [15:0] stat_reg;
    logic [15:0] mbox_reg;
    logic [15:0] dram_shadow [int];
    int          dram_written [$];

    reply_t awaited_replies [$];
    row_t   directed_rows [$];
    int     errors;
    bit     calm;

    initial begin
        clk = 1'b0;
        forever
        begin
            #2 clk = 1'b1;
            #2 clk = 1'b0;
        end
    end

    initial begin
        #2000000;
        $display("tb_top: FAIL");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [31:0] ptr_stride(logic [15:0] mode);
        logic [31:0] s;
        case (mode[13:11])
            3'd0: s = 0;
            3'd7: s = 128;
            default: s = 32'd1 << (mode[13:11] - 1);
        endcase
        return mode[15] ? -s : s;
    endfunction

    function automatic int window_addr(logic [20:0] off);
        logic [20:0] a;
        if (off >= 21'h180000 && off < 21'h190000)
            return int'(off - 21'h180000);
        if (off >= 21'h1c8000 && off < 21'h1d0000)
        begin
            a = off - 21'h1c8000;
            return int'((a & 21'h7001) | ((a & 21'h3e) << 6) | ((a & 21'hfc0) >> 5));
        end
        if (off >= 21'h1d0000 && off < 21'h1d8000)
        begin
            a = off - 21'h1d0000;
            return int'((a & 21'h7801) | ((a & 21'h1e) << 6) | ((a & 21'h7e0) >> 4));
        end
        return -1;
    endfunction

    // DRAM word that this access would read, or -1
    function automatic int dram_read_of(access_t a);
        logic [31:0] p;
        logic [15:0] mode;
        if (a.cmd == pmpc_pkg::CMD_CART_RD)
            return window_addr(a.off);
        if (a.cmd > pmpc_pkg::CMD_DSP_WR || a.port > pmpc_pkg::PORT_PM4 || phase[1])
            return -1;
        if (a.port != pmpc_pkg::PORT_PM4 && a.gpo == 0)
            return -1;
        p = a.cmd[0] ? wr_ptr[a.port] : rd_ptr[a.port];
        mode = p[31:16];
        if (a.cmd[0])
        begin
            if (mode[10] && ((mode & pmpc_pkg::WR_DRAM_MASK) == pmpc_pkg::WR_DRAM_VAL
                             || (mode & pmpc_pkg::WR_CELL_MASK) == pmpc_pkg::WR_CELL_VAL))
                return int'(p[15:0]);
        end
        else if ((mode & pmpc_pkg::ROM_MASK) != pmpc_pkg::ROM_VAL
                 && (mode & pmpc_pkg::IRAM_MASK) == pmpc_pkg::RD_DRAM_VAL)
            return int'(p[15:0]);
        return -1;
    endfunction

    task automatic dram_put(int a, logic [15:0] d, bit merge);
        logic [15:0] v;
        if (!dram_shadow.exists(a))
            dram_written.push_back(a);
        v = merge ? dram_shadow[a] : d;
        if (merge)
            for (int i = 0; i < 4; i++)
                if (d[i*4 +: 4] != 0)
                    v[i*4 +: 4] = d[i*4 +: 4];
        dram_shadow[a] = v;
    endtask

    task automatic compute_reply(input access_t a, output reply_t r);
        logic [31:0] p;
        logic [15:0] mode, addr, lo;
        bit          wr;
        r = '0;
        wr = a.cmd[0];
        case (a.cmd)
            pmpc_pkg::CMD_DSP_RD, pmpc_pkg::CMD_DSP_WR:
            begin
                if (a.port <= pmpc_pkg::PORT_PM4)
                begin
                    if (phase[1])
                    begin
                        if (wr)
                            wr_ptr[a.port] = ctl_word;
                        else
                            rd_ptr[a.port] = ctl_word;
                        phase[1] = 1'b0;
                    end
                    else
                    begin
                        phase[0] = 1'b0;
                        if (a.port == pmpc_pkg::PORT_PM4 || a.gpo != 0)
                        begin
                            p = wr ? wr_ptr[a.port] : rd_ptr[a.port];
                            mode = p[31:16];
                            addr = p[15:0];
                            if (wr)
                            begin
                                if ((mode & pmpc_pkg::WR_DRAM_MASK) == pmpc_pkg::WR_DRAM_VAL)
                                begin
                                    dram_put(int'(addr), a.wd, mode[10]);
                                    p += ptr_stride(mode);
                                end
                                else if ((mode & pmpc_pkg::WR_CELL_MASK)
                                         == pmpc_pkg::WR_CELL_VAL)
                                begin
                                    dram_put(int'(addr), a.wd, mode[10]);
                                    p += addr[0] ? 31 : 1;
                                end
                                else if ((mode & pmpc_pkg::IRAM_MASK) == pmpc_pkg::IRAM_VAL)
                                    p += ptr_stride(mode);
                                else
                                    r.oc = pmpc_pkg::OC_BAD_MODE;
                            end
                            else
                            begin
                                if ((mode & pmpc_pkg::ROM_MASK) == pmpc_pkg::ROM_VAL)
                                begin
                                    r.rreq = 1'b1;
                                    r.raddr = {mode[3:0], addr};
                                    p += 1;
                                end
                                else if ((mode & pmpc_pkg::IRAM_MASK)
                                         == pmpc_pkg::RD_DRAM_VAL)
                                begin
                                    r.rd = dram_shadow[int'(addr)];
                                    p += ptr_stride(mode);
                                end
                                else
                                    r.oc = pmpc_pkg::OC_BAD_MODE;
                            end
                            if (wr)
                                wr_ptr[a.port] = p;
                            else
                                rd_ptr[a.port] = p;
                            ctl_word = p;
                        end
                        else if (a.port == 0)
                        begin
                            if (wr)
                                mbox_reg = a.wd;
                            else
                            begin
                                r.rd = mbox_reg;
                                mbox_reg[1] = 1'b0;
                            end
                        end
                        else if (a.port == pmpc_pkg::PORT_STATUS)
                        begin
                            if (wr)
                            begin
                                mbox_reg[0] = 1'b1;
                                stat_reg = a.wd;
                            end
                            else
                                r.rd = stat_reg;
                        end
                        else
                            r.oc = pmpc_pkg::OC_NO_PTR;
                    end
                end
                else if (a.port == pmpc_pkg::PORT_CONTROL)
                begin
                    lo = ctl_word[15:0];
                    if (phase[0])
                    begin
                        phase = 2'b10;
                        if (wr)
                            ctl_word[31:16] = a.wd;
                        else
                            r.rd = {lo[11:0], lo[7:4]};
                    end
                    else
                    begin
                        phase[0] = 1'b1;
                        if (wr)
                            ctl_word[15:0] = a.wd;
                        else
                            r.rd = lo;
                    end
                end
                else if (a.port == pmpc_pkg::PORT_AL && !wr)
                    phase = 2'b00;
            end
            pmpc_pkg::CMD_CART_RD:
            begin
                if (window_addr(a.off) >= 0)
                    r.rd = dram_shadow[window_addr(a.off)];
                else if (a.off < 21'h100000)
                begin
                    r.rreq = 1'b1;
                    r.raddr = a.off[19:0];
                end
                else
                begin
                    r.rd = 16'hffff;
                    r.oc = pmpc_pkg::OC_UNMAPPED;
                end
            end
            pmpc_pkg::CMD_CART_WR:
            begin
                if (a.off >= 21'h180000 && a.off < 21'h190000)
                    dram_put(int'(a.off - 21'h180000), a.wd, 1'b0);
                else
                    r.oc = pmpc_pkg::OC_UNMAPPED;
            end
            pmpc_pkg::CMD_REG_RD:
            begin
                if (a.off <= 1)
                    r.rd = stat_reg;
                else if (a.off == 2)
                begin
                    r.rd = mbox_reg;
                    mbox_reg[0] = 1'b0;
                end
                else
                    r.oc = pmpc_pkg::OC_UNMAPPED;
            end
            pmpc_pkg::CMD_REG_WR:
            begin
                if (a.off <= 1)
                begin
                    stat_reg = a.wd;
                    mbox_reg[1] = 1'b1;
                end
                else if (a.off != 3)
                    r.oc = pmpc_pkg::OC_UNMAPPED;
            end
            default: ;
        endcase
    endtask

    task automatic report(string what, logic [19:0] got, logic [19:0] want);
        $display("%0t mismatch %s: got %h, want %h", $realtime, what, got, want);
        errors++;
    endtask

    // drive one transaction; never let it read a DRAM word not yet written
    task automatic issue(access_t a, bit known, reply_t typed);
        reply_t r;
        int     gap, da;
        da = dram_read_of(a);
        if (da >= 0 && !dram_shadow.exists(da))
        begin
            a.cmd = pmpc_pkg::CMD_CART_WR;
            a.off = 21'h180000 + da;
            known = 1'b0;
        end
        compute_reply(a, r);
        awaited_replies.push_back(known ? typed : r);
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        command <= a.cmd;
        port <= a.port;
        host_offset <= a.off;
        write_data <= a.wd;
        gpo_bits <= a.gpo;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic send(logic [2:0] c, logic [2:0] p, logic [20:0] o, logic [15:0] d,
                        logic [1:0] g);
        issue('{cmd: c, port: p, off: o, wd: d, gpo: g}, 1'b0, '0);
    endtask

    function automatic void add_row(logic [2:0] c, logic [2:0] p, logic [20:0] o,
                                    logic [15:0] d, logic [1:0] g, bit k,
                                    logic [15:0] rd, logic rq, logic [19:0] ra,
                                    logic [1:0] oc);
        row_t x;
        x.acc = '{cmd: c, port: p, off: o, wd: d, gpo: g};
        x.known = k;
        x.rep = '{rd: rd, rreq: rq, raddr: ra, oc: oc};
        directed_rows.push_back(x);
    endfunction

    function automatic logic [15:0] some_addr();
        if (dram_written.size() > 0 && $urandom_range(0, 9) < 7)
            return dram_written[$urandom_range(0, dram_written.size() - 1)];
        return $urandom_range(0, 1) ? $urandom_range(0, 255) : $urandom_range(0, 65535);
    endfunction

    task automatic pointer_burst();
        logic [2:0]  p;
        logic [15:0] mode;
        logic [2:0]  inc;
        bit          wr;
        int          n;
        p = $urandom_range(0, 4);
        inc = $urandom_range(0, 7);
        case ($urandom_range(0, 5))
            0: begin wr = 1; mode = 16'h0018 | (inc << 11)
                   | ($urandom_range(0, 1) << 15) | ($urandom_range(0, 1) << 10); end
            1: begin wr = 1; mode = 16'h4018 | ($urandom_range(0, 1) << 10); end
            2: begin wr = 1; mode = 16'h001c | (inc << 11) | ($urandom_range(0, 1) << 15); end
            3: begin wr = 0; mode = 16'h0800 | $urandom_range(0, 15); end
            4: begin wr = 0; mode = 16'h0018 | (inc << 11) | ($urandom_range(0, 1) << 15); end
            default: begin wr = $urandom_range(0, 1); mode = $urandom_range(0, 65535); end
        endcase
        send(pmpc_pkg::CMD_DSP_RD, pmpc_pkg::PORT_AL, $urandom, $urandom, $urandom);
        send(pmpc_pkg::CMD_DSP_WR, pmpc_pkg::PORT_CONTROL, $urandom, some_addr(), $urandom);
        send(pmpc_pkg::CMD_DSP_WR, pmpc_pkg::PORT_CONTROL, $urandom, mode, $urandom);
        send({2'b00, wr}, p, $urandom, $urandom, $urandom);
        n = $urandom_range(1, 6);
        repeat (n)
            send({2'b00, wr}, p, $urandom, $urandom,
                 p == pmpc_pkg::PORT_PM4 ? $urandom_range(0, 3) : $urandom_range(1, 3));
    endtask

    task automatic cart_read();
        logic [15:0] d;
        int          k;
        k = $urandom_range(0, 9);
        d = some_addr();
        if (k < 4)
            send(pmpc_pkg::CMD_CART_RD, $urandom, 21'h180000 + d, $urandom, $urandom);
        else if (k < 6 && !d[15])
            send(pmpc_pkg::CMD_CART_RD, $urandom, 21'h1c8000
                 + ((d & 16'h7001) | ((d >> 6) & 16'h3e) | ((d << 5) & 16'hfc0)),
                 $urandom, $urandom);
        else if (k < 8 && !d[15])
            send(pmpc_pkg::CMD_CART_RD, $urandom, 21'h1d0000
                 + ((d & 16'h7801) | ((d >> 6) & 16'h1e) | ((d << 4) & 16'h7e0)),
                 $urandom, $urandom);
        else
            send(pmpc_pkg::CMD_CART_RD, $urandom, $urandom_range(0, 21'h1fffff),
                 $urandom, $urandom);
    endtask

    always @(posedge clk)
    begin
        reply_t w;
        if (rst_n && out_valid && !out_stall)
        begin
            if (awaited_replies.size() == 0)
                report("unexpected transaction", read_data, 0);
            else
            begin
                w = awaited_replies.pop_front();
                if (read_data !== w.rd)
                    report("read_data", read_data, w.rd);
                if (rom_request !== w.rreq)
                    report("rom_request", rom_request, w.rreq);
                if (rom_address !== w.raddr)
                    report("rom_address", rom_address, w.raddr);
                if (outcome !== w.oc)
                    report("outcome", outcome, w.oc);
            end
        end
    end

    int hold_left;
    always @(posedge clk)
    begin
        if (hold_left > 0)
            hold_left--;
        else
            hold_left = pick_gap();
        out_stall <= (hold_left != 0);
    end

    initial begin
        int k;
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        command = '0;
        port = '0;
        host_offset = '0;
        write_data = '0;
        gpo_bits = '0;
        errors = 0;
        calm = 1'b0;
        hold_left = 0;
        for (int i = 0; i < 5; i++)
        begin
            rd_ptr[i] = '0;
            wr_ptr[i] = '0;
        end
        ctl_word = '0;
        phase = '0;
        stat_reg = '0;
        mbox_reg = '0;

        add_row(pmpc_pkg::CMD_REG_RD, 0, 21'd0, 0, 0, 1, 16'h0000, 0, 0, pmpc_pkg::OC_OK);
        add_row(pmpc_pkg::CMD_REG_RD, 0, 21'd2, 0, 0, 1, 16'h0000, 0, 0, pmpc_pkg::OC_OK);
        add_row(pmpc_pkg::CMD_REG_RD, 7, 21'h1fffff, 16'hffff, 3, 1, 16'h0000, 0, 0,
                pmpc_pkg::OC_UNMAPPED);
        add_row(pmpc_pkg::CMD_CART_RD, 0, 21'h1fffff, 0, 0, 1, 16'hffff, 0, 0,
                pmpc_pkg::OC_UNMAPPED);
        add_row(pmpc_pkg::CMD_CART_RD, 0, 21'd0, 0, 0, 1, 16'h0000, 1, 20'h00000,
                pmpc_pkg::OC_OK);
        add_row(pmpc_pkg::CMD_CART_RD, 0, 21'h0fffff, 0, 0, 1, 16'h0000, 1, 20'hfffff,
                pmpc_pkg::OC_OK);
        add_row(pmpc_pkg::CMD_CART_WR, 0, 21'h180000, 16'hffff, 0, 1, 16'h0000, 0, 0,
                pmpc_pkg::OC_OK);
        add_row(pmpc_pkg::CMD_CART_WR, 0, 21'h18ffff, 16'h0000, 0, 1, 16'h0000, 0, 0,
                pmpc_pkg::OC_OK);
        add_row(pmpc_pkg::CMD_CART_RD, 0, 21'h180000, 0, 0, 1, 16'hffff, 0, 0,
                pmpc_pkg::OC_OK);
        add_row(pmpc_pkg::CMD_CART_WR, 0, 21'h100000, 16'h1234, 0, 1, 16'h0000, 0, 0,
                pmpc_pkg::OC_UNMAPPED);
        add_row(pmpc_pkg::CMD_REG_WR, 0, 21'd0, 16'ha5a5, 0, 1, 16'h0000, 0, 0,
                pmpc_pkg::OC_OK);
        add_row(pmpc_pkg::CMD_REG_WR, 0, 21'd3, 16'h5a5a, 0, 1, 16'h0000, 0, 0,
                pmpc_pkg::OC_OK);
        add_row(pmpc_pkg::CMD_REG_WR, 0, 21'd7, 16'h5a5a, 0, 1, 16'h0000, 0, 0,
                pmpc_pkg::OC_UNMAPPED);
        add_row(pmpc_pkg::CMD_DSP_RD, 1, 0, 0, 0, 1, 16'h0000, 0, 0, pmpc_pkg::OC_NO_PTR);
        add_row(pmpc_pkg::CMD_DSP_WR, 5, 0, 16'hffff, 0, 1, 16'h0000, 0, 0, pmpc_pkg::OC_OK);
        add_row(3'd6, 0, 21'h1fffff, 16'hffff, 3, 1, 16'h0000, 0, 0, pmpc_pkg::OC_OK);
        add_row(3'd7, 7, 21'h1fffff, 16'hffff, 3, 1, 16'h0000, 0, 0, pmpc_pkg::OC_OK);
        add_row(pmpc_pkg::CMD_DSP_RD, pmpc_pkg::PORT_PM4, 0, 0, 0, 1, 16'h0000, 0, 0,
                pmpc_pkg::OC_BAD_MODE);
        add_row(pmpc_pkg::CMD_DSP_WR, pmpc_pkg::PORT_PM4, 0, 16'h1111, 0, 1, 16'h0000, 0, 0,
                pmpc_pkg::OC_BAD_MODE);
        add_row(pmpc_pkg::CMD_DSP_RD, pmpc_pkg::PORT_AL, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(pmpc_pkg::CMD_DSP_WR, pmpc_pkg::PORT_CONTROL, 0, 16'h0000, 0, 0, 0, 0, 0, 0);
        add_row(pmpc_pkg::CMD_DSP_WR, pmpc_pkg::PORT_CONTROL, 0,
                16'h0818 & ~16'h0800 | 16'h0800, 0, 0, 0, 0, 0, 0);
        add_row(pmpc_pkg::CMD_DSP_RD, pmpc_pkg::PORT_PM4, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(pmpc_pkg::CMD_DSP_RD, pmpc_pkg::PORT_PM4, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(pmpc_pkg::CMD_DSP_RD, pmpc_pkg::PORT_CONTROL, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(pmpc_pkg::CMD_DSP_RD, pmpc_pkg::PORT_CONTROL, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(pmpc_pkg::CMD_DSP_WR, 0, 0, 16'h00ff, 0, 0, 0, 0, 0, 0);
        add_row(pmpc_pkg::CMD_DSP_RD, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(pmpc_pkg::CMD_DSP_WR, pmpc_pkg::PORT_STATUS, 0, 16'hbeef, 0, 0, 0, 0, 0, 0);
        add_row(pmpc_pkg::CMD_DSP_RD, pmpc_pkg::PORT_STATUS, 0, 0, 0, 0, 0, 0, 0, 0);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            issue(directed_rows[i].acc, directed_rows[i].known, directed_rows[i].rep);

        // hold until the block has drained
        in_valid <= 1'b0;
        while (awaited_replies.size() != 0)
            @(posedge clk);

        for (int n = 0; n < 125; n++)
        begin
            if (n % 12 == 0)
                calm = ($urandom_range(0, 3) == 0);
            k = $urandom_range(0, 99);
            if (k < 35)
                pointer_burst();
            else if (k < 50)
                send(pmpc_pkg::CMD_CART_WR, $urandom, $urandom_range(0, 9) == 0
                     ? $urandom_range(0, 21'h1fffff)
                     : 21'h180000 + ($urandom_range(0, 1) ? $urandom_range(0, 255)
                                                        : $urandom_range(0, 65535)),
                     $urandom, $urandom);
            else if (k < 65)
                cart_read();
            else if (k < 75)
                send($urandom_range(pmpc_pkg::CMD_REG_RD, pmpc_pkg::CMD_REG_WR), $urandom,
                     $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, 21'h1fffff),
                     $urandom, $urandom);
            else if (k < 88)
                send($urandom_range(0, 1), $urandom, $urandom, $urandom,
                     $urandom_range(0, 1) ? 2'd0 : $urandom_range(0, 3));
            else if (k < 92)
                send($urandom_range(6, 7), $urandom, $urandom, $urandom, $urandom);
            else
                send($urandom_range(0, 1), $urandom_range(0, 4), $urandom, $urandom,
                     $urandom_range(1, 3));
        end

        in_valid <= 1'b0;
        while (awaited_replies.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end
endmodule
`default_nettype wire
